// ===== rtl/core/fqs_pkg.sv =====
// Shared types and constants for the searchable FIFO queue.
// No dependencies; imported by every module of the block except fqs_ram.
package fqs_pkg;

    // Queue geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int ST_W   = 2;

    // Request opcodes as they arrive on the input channel
    localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // Result status codes
    localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [ST_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [ST_W-1:0] STATUS_EMPTY = 2'd2;

    // Decoded command kind, as handed from front to back
    typedef enum logic [2:0] {
        KIND_NOP    = 3'd0,
        KIND_ENQ    = 3'd1,
        KIND_DEQ    = 3'd2,
        KIND_PEEK   = 3'd3,
        KIND_SEARCH = 3'd4,
        KIND_CLEAR  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [DATA_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic                      found;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          count;
        logic                      empty_res;
        logic [ST_W-1:0]           status;
    } t_res;

    // Advance a ring index, wrapping at the last slot
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        nxt = (idx == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(idx + 1'b1);
        return nxt;
    endfunction

endpackage

// ===== rtl/core/fqs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, and register the read word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/fqs_front.sv =====
// Front end: accepts requests, decodes the opcode and queues the commands.
// Depends on fqs_pkg.
module fqs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [fqs_pkg::OP_W-1:0]      i_operation,
    input  logic signed [fqs_pkg::DATA_W-1:0] i_value,
    output logic                          o_cmd_valid,
    output fqs_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);
    import fqs_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    // Classify the request
    always_comb begin
        w_cmd.value = i_value;
        case (i_operation)
            OP_ENQUEUE: w_cmd.kind = KIND_ENQ;
            OP_DEQUEUE: w_cmd.kind = KIND_DEQ;
            OP_PEEK:    w_cmd.kind = KIND_PEEK;
            OP_SEARCH:  w_cmd.kind = KIND_SEARCH;
            OP_CLEAR:   w_cmd.kind = KIND_CLEAR;
            default:    w_cmd.kind = KIND_NOP;
        endcase
    end

    // Hold off the sender while both command slots are taken
    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;

    // Advance pointers and fill level
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = ~r_wp;
        end
        if (i_cmd_pop) begin
            n_rp = ~r_rp;
        end
        case ({w_push, i_cmd_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the decoded command
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

endmodule

// ===== rtl/core/fqs_back.sv =====
// Back end: owns the ring pointers and the slot RAM, executes one command at
// a time and drives the output register. Depends on fqs_pkg and fqs_ram.
module fqs_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  fqs_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [fqs_pkg::DATA_W-1:0] o_data,
    output logic                              o_found,
    output logic [fqs_pkg::POS_W-1:0]         o_position,
    output logic [fqs_pkg::POS_W-1:0]         o_count,
    output logic                              o_empty_res,
    output logic [fqs_pkg::ST_W-1:0]          o_status
);
    import fqs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_head, n_head;
    logic [IDX_W-1:0]         r_tail, n_tail;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [CNT_W-1:0]         r_ik, n_ik;
    logic [IDX_W-1:0]         r_addr, n_addr;
    t_res                     r_res, n_res;
    t_res                     r_out, n_out;

    logic                     w_out_free;
    logic                     w_wr_en;
    logic                     w_rd_en;
    logic [IDX_W-1:0]         w_rd_addr;
    logic [DATA_W-1:0]        w_rd_data;

    fqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_out_free = !r_out_valid || !i_stall;

    // Sequence one command
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_value     = r_value;
        n_ik        = r_ik;
        n_addr      = r_addr;
        n_res       = r_res;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_head;

        // Drop the result once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_res     = '0;
                    n_state   = ST_DONE;
                    case (i_cmd.kind)
                        KIND_ENQ: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_res.status = STATUS_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_tail  = ring_next(r_tail);
                                n_count = CNT_W'(r_count + 1'b1);
                            end
                        end
                        KIND_DEQ, KIND_PEEK: begin
                            if (r_count == '0) begin
                                n_res.status = STATUS_EMPTY;
                            end else begin
                                w_rd_en = 1'b1;
                                n_state = ST_READ;
                                if (i_cmd.kind == KIND_DEQ) begin
                                    n_head  = ring_next(r_head);
                                    n_count = CNT_W'(r_count - 1'b1);
                                end
                            end
                        end
                        KIND_SEARCH: begin
                            n_value = i_cmd.value;
                            if (r_count != '0) begin
                                w_rd_en = 1'b1;
                                n_addr  = ring_next(r_head);
                                n_ik    = CNT_W'(1);
                                n_state = ST_SEARCH;
                            end
                        end
                        KIND_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                    n_res.count     = POS_W'(n_count);
                    n_res.empty_res = (n_count == '0);
                end
            end
            ST_READ: begin
                n_res.data = $signed(w_rd_data);
                n_state    = ST_DONE;
            end
            ST_SEARCH: begin
                // Compare the entry fetched last cycle, fetch the next one
                if ($signed(w_rd_data) == r_value) begin
                    n_res.found    = 1'b1;
                    n_res.position = POS_W'(r_ik);
                    n_state        = ST_DONE;
                end else if (r_ik < r_count) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_addr;
                    n_addr    = ring_next(r_addr);
                    n_ik      = CNT_W'(r_ik + 1'b1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_ik    <= n_ik;
        r_addr  <= n_addr;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_valid     = r_out_valid;
    assign o_data      = r_out.data;
    assign o_found     = r_out.found;
    assign o_position  = r_out.position;
    assign o_count     = r_out.count;
    assign o_empty_res = r_out.empty_res;
    assign o_status    = r_out.status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above queue depth");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> (r_ik != '0 && r_ik <= r_count))
        else $error("search index outside stored entries");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.found |-> r_out.position != '0)
        else $error("search hit without a position");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.empty_res == (r_out.count == '0)))
        else $error("empty flag disagrees with count");

    a_pointers_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |=> $stable(r_head) && $stable(r_count))
        else $error("queue pointers moved during a search");

endmodule

// ===== rtl/core/fifo_queue_with_search.sv =====
// Searchable FIFO queue of signed 32-bit values in a 16-slot ring.
// Enqueue, clear and refused requests pass from acceptance through the done state to
// the output register; dequeue and peek read the slot RAM first; a search compares one
// entry per cycle from the front until a match or the end. One command runs at a
// time; a two-entry command queue lets the input side run ahead by two items.
// Reset (synchronous, active low) empties the queue; slot contents are kept.
module fifo_queue_with_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [fqs_pkg::OP_W-1:0]          i_operation,
    input  logic signed [fqs_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [fqs_pkg::DATA_W-1:0] o_data,
    output logic                              o_found,
    output logic [fqs_pkg::POS_W-1:0]         o_position,
    output logic [fqs_pkg::POS_W-1:0]         o_count,
    output logic                              o_empty_res,
    output logic [fqs_pkg::ST_W-1:0]          o_status
);
    import fqs_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    // Accept and decode
    fqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Execute against the ring
    fqs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_status    (o_status)
    );

endmodule

// ===== bench/queue_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the searchable FIFO queue: keeps its own ring model, predicts
// the result of every accepted request and compares results in order. Uses fqs_pkg.
module queue_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_stall,
    input  logic [fqs_pkg::OP_W-1:0]          i_operation,
    input  logic signed [fqs_pkg::DATA_W-1:0] i_value,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic signed [fqs_pkg::DATA_W-1:0] i_data,
    input  logic                              i_found,
    input  logic [fqs_pkg::POS_W-1:0]         i_position,
    input  logic [fqs_pkg::POS_W-1:0]         i_count,
    input  logic                              i_empty_res,
    input  logic [fqs_pkg::ST_W-1:0]          i_status,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_hits,
    output int                                o_refused
);
    import fqs_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Model of the ring: slot contents, front, next write slot and fill level
    logic signed [DATA_W-1:0] model_slots [DEPTH];
    int                       model_head;
    int                       model_tail;
    int                       model_count;

    // Results predicted but not yet seen on the output channel
    t_res                     expected_results [$];

    // Apply one request to the model and return the result it must produce
    function automatic t_res queue_outcome(input logic [OP_W-1:0] op,
                                           input logic signed [DATA_W-1:0] val);
        t_res res;
        int   k;
        res = '0;
        case (op)
            OP_ENQUEUE: begin
                if (model_count >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    model_slots[model_tail] = val;
                    model_tail = (model_tail + 1) % DEPTH;
                    model_count++;
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (model_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.data = model_slots[model_head];
                    if (op == OP_DEQUEUE) begin
                        model_head = (model_head + 1) % DEPTH;
                        model_count--;
                    end
                end
            end
            OP_SEARCH: begin
                // Walk stored entries from the front, stop at the first match
                for (k = 0; k < model_count && !res.found; k++) begin
                    if (model_slots[(model_head + k) % DEPTH] == val) begin
                        res.found    = 1'b1;
                        res.position = POS_W'(k + 1);
                    end
                end
            end
            OP_CLEAR: begin
                model_head  = 0;
                model_tail  = 0;
                model_count = 0;
            end
            default: begin
            end
        endcase
        res.count     = POS_W'(model_count);
        res.empty_res = (model_count == 0);
        return res;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin : watch
        t_res predicted;
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            model_head   = 0;
            model_tail   = 0;
            model_count  = 0;
            expected_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
            o_hits       = 0;
            o_refused    = 0;
        end else begin
            if (i_req_valid && !i_req_stall) begin
                predicted = queue_outcome(i_operation, i_value);
                if (predicted.found) o_hits++;
                if (predicted.status != STATUS_OK) o_refused++;
                expected_results.push_back(predicted);
            end
            if (i_res_valid && !i_res_stall) begin
                got.data      = i_data;
                got.found     = i_found;
                got.position  = i_position;
                got.count     = i_count;
                got.empty_res = i_empty_res;
                got.status    = i_status;
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("%0t: result with none pending: data=%0d count=%0d status=%0d",
                                 $time, got.data, got.count, got.status);
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (got.data !== want.data || got.found !== want.found ||
                        got.position !== want.position || got.count !== want.count ||
                        got.empty_res !== want.empty_res || got.status !== want.status) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT) begin
                            $display("%0t: mismatch exp data=%0d fnd=%0b pos=%0d cnt=%0d",
                                     $time, want.data, want.found, want.position,
                                     want.count);
                            $display("    exp empty=%0b st=%0d", want.empty_res,
                                     want.status);
                            $display("    got data=%0d fnd=%0b pos=%0d cnt=%0d",
                                     got.data, got.found, got.position, got.count);
                            $display("    got empty=%0b st=%0d", got.empty_res,
                                     got.status);
                        end
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Bench top for the searchable FIFO queue: clock, reset, request stimulus, output
// stall pattern and verdict. Uses fqs_pkg, fifo_queue_with_search, queue_result_checker.
module testbench;
    import fqs_pkg::*;

    localparam int     HOLD_CYCLES     = 240;
    localparam int     ITEMS_PER_PHASE = 350;
    localparam int     SEGMENT_ITEMS   = 40;
    localparam int     SETTLE_CYCLES   = 40;
    localparam longint LIMIT_NS        = 4_000_000;

    // Codes past the last defined operation; the block treats them as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [OP_W-1:0]          req_operation;
    logic signed [DATA_W-1:0] req_value;
    logic                     res_valid;
    logic                     res_stall;
    logic signed [DATA_W-1:0] res_data;
    logic                     res_found;
    logic [POS_W-1:0]         res_position;
    logic [POS_W-1:0]         res_count;
    logic                     res_empty;
    logic [ST_W-1:0]          res_status;

    int                       send_idle_pct;
    int                       recv_idle_pct;
    logic                     hold_request;
    logic                     hold_done;
    int                       requests_sent;
    int                       mismatches;
    int                       pending;
    int                       checked;
    int                       hits;
    int                       refused;
    logic signed [DATA_W-1:0] value_pool [8];
    logic signed [DATA_W-1:0] fill_values [DEPTH];
    int                       bias_choices [3] = '{20, 45, 70};

    fifo_queue_with_search u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_stall     (req_stall),
        .i_operation (req_operation),
        .i_value     (req_value),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_data      (res_data),
        .o_found     (res_found),
        .o_position  (res_position),
        .o_count     (res_count),
        .o_empty_res (res_empty),
        .o_status    (res_status)
    );

    queue_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_operation  (req_operation),
        .i_value      (req_value),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_data       (res_data),
        .i_found      (res_found),
        .i_position   (res_position),
        .i_count      (res_count),
        .i_empty_res  (res_empty),
        .i_status     (res_status),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_refused    (refused)
    );

    // Generate the 8 ns clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial begin
        #(LIMIT_NS);
        $display("testbench NOT OK");
        $finish;
    end

    // Drive output stall: decide at the rising edge, apply at the falling edge
    initial begin : receiver
        int   hold_left;
        logic next_stall;
        res_stall = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                next_stall = 1'b1;
                hold_left--;
            end else begin
                next_stall = ($urandom_range(99) < recv_idle_pct);
            end
            @(negedge clk);
            res_stall = next_stall;
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic offer_request(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] val,
                                 input logic start_hold);
        @(negedge clk);
        if (start_hold) hold_request = 1'b1;
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid     = 1'b1;
        req_operation = op;
        req_value     = val;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        requests_sent++;
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic wait_results_done();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Pick a random request; enq_bias steers the fill level
    task automatic offer_random(input int enq_bias, input logic start_hold);
        int                       r;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        r = $urandom_range(99);
        if (r < 2) begin
            op = OP_CLEAR;
        end else if (r < 5) begin
            op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        end else if (r < 5 + enq_bias) begin
            op = OP_ENQUEUE;
        end else begin
            r = $urandom_range(2);
            if (r == 0) op = OP_DEQUEUE;
            else if (r == 1) op = OP_PEEK;
            else op = OP_SEARCH;
        end
        // Draw from a small pool often so searches hit and duplicates occur
        if ($urandom_range(99) < 60) val = value_pool[$urandom_range(7)];
        else val = $urandom;
        offer_request(op, val, start_hold);
    endtask

    // Run one random phase under the given idling mix
    task automatic run_phase(input int send_pct, input int recv_pct, input logic with_hold);
        int bias;
        int i;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        bias          = bias_choices[0];
        for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % SEGMENT_ITEMS == 0) bias = bias_choices[$urandom_range(2)];
            offer_random(bias, with_hold && (i == 30));
        end
        wait_results_done();
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        int i;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_operation = OP_ENQUEUE;
        req_value     = '0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        requests_sent = 0;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (i = 4; i < 8; i++) value_pool[i] = $urandom;

        fill_values = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
                        32'sd5, 32'sh7fff_ffff, 32'sd7, 32'sh5555_5555,
                        32'shaaaa_aaaa, 32'sd9, 32'sd10, 32'sd11,
                        32'sd12, 32'sd13, 32'sd14, 32'sh0f0f_0f0f};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty refusals, fill to full, refused enqueue, searches,
        // dequeue, spare codes, clear and a search on the cleared queue
        offer_request(OP_DEQUEUE, 32'sd0, 1'b0);
        offer_request(OP_PEEK, 32'sd0, 1'b0);
        for (i = 0; i < DEPTH; i++) offer_request(OP_ENQUEUE, fill_values[i], 1'b0);
        offer_request(OP_ENQUEUE, 32'sd99, 1'b0);
        offer_request(OP_PEEK, 32'sd0, 1'b0);
        offer_request(OP_SEARCH, 32'sh0f0f_0f0f, 1'b0);
        offer_request(OP_SEARCH, 32'sh7fff_ffff, 1'b0);
        offer_request(OP_DEQUEUE, 32'sd0, 1'b0);
        offer_request(OP_SPARE_FIRST, 32'sd0, 1'b0);
        offer_request(OP_SPARE_LAST, -32'sd1, 1'b0);
        offer_request(OP_CLEAR, 32'sd0, 1'b0);
        offer_request(OP_SEARCH, 32'sd0, 1'b0);
        wait_results_done();

        // Random phases: slow receiver, then slow sender, then full rate with a hold-off
        run_phase(26, 75, 1'b0);
        run_phase(75, 26, 1'b0);
        run_phase(0, 0, 1'b1);

        // Let any late result show up before the verdict
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d requests under three idling mixes and a %0d-cycle output hold-off",
                 requests_sent, HOLD_CYCLES);
        $display("compared %0d results: %0d search hits, %0d refused requests",
                 checked, hits, refused);
        if (mismatches == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fqs_pkg.sv
rtl/core/fqs_ram.sv
rtl/core/fqs_front.sv
rtl/core/fqs_back.sv
rtl/core/fifo_queue_with_search.sv
bench/queue_result_checker.sv
bench/testbench.sv
